FILE: hw/rtl/ftm_pkg.sv
// Shared types and constants for the footswitch to MIDI mapper.
// Used by ftm_decode, footswitch_to_midi_mapper and ftm_checker.
`default_nettype none

package ftm_pkg;

  localparam int unsigned SwitchCountDflt = 3;
  // Switches that have fields in the configuration registers.
  localparam int unsigned CfgSwitches     = 3;
  localparam int unsigned CfgIdxW         = 3;
  localparam int unsigned CfgDataW        = 21;
  localparam logic [6:0]  MidiMax         = 7'd127;

  typedef enum logic [2:0] {
    CFG_MIDI_ENABLED      = 3'd0,
    CFG_SWITCH_MODES      = 3'd1,
    CFG_SWITCH_BEHAVIOURS = 3'd2,
    CFG_SWITCH_CHANNELS   = 3'd3,
    CFG_SWITCH_CC_NUMBERS = 3'd4,
    CFG_EXPR_CHANNEL      = 3'd5,
    CFG_EXPR_CC_NUMBER    = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_CC        = 2'd0,
    MODE_PROG_NEXT = 2'd1,
    MODE_PROG_BACK = 2'd2,
    MODE_NONE      = 2'd3
  } mode_e;

  typedef enum logic {
    REQ_SWITCH = 1'b0,
    REQ_EXPR   = 1'b1
  } req_type_e;

  typedef enum logic {
    KIND_CC = 1'b0,
    KIND_PC = 1'b1
  } msg_kind_e;

  typedef struct packed {
    logic        midi_enabled;
    logic [5:0]  switch_modes;
    logic [2:0]  switch_behaviours;
    logic [11:0] switch_channels;
    logic [20:0] switch_cc_numbers;
    logic [3:0]  expr_channel;
    logic [6:0]  expr_cc_number;
  } ftm_cfg_t;

  typedef struct packed {
    logic               req_type;
    logic [2:0]         pedal_index;
    logic               pressed;
    logic signed [15:0] expr_value;
  } ftm_req_t;

  typedef struct packed {
    logic       emit;
    msg_kind_e  kind;
    logic [3:0] chan;
    logic [6:0] number;
    logic [6:0] value;
  } ftm_result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ftm_decode.sv
// Per-request decode: maps one pedal request to a MIDI message and next state.
// Purely combinational; depends on ftm_pkg.
`default_nettype none

module ftm_decode
  import ftm_pkg::*;
#(
  parameter int unsigned SWITCH_COUNT = SwitchCountDflt,
  localparam int unsigned FlagCount =
    (SWITCH_COUNT < CfgSwitches) ? SWITCH_COUNT : CfgSwitches
) (
  input  ftm_cfg_t             cfg_i,
  input  ftm_req_t             req_i,
  input  logic [FlagCount-1:0] flags_i,
  input  logic [6:0]           prog_i,
  output ftm_result_t          res_o,
  output logic [FlagCount-1:0] flags_o,
  output logic [6:0]           prog_o
);

  mode_e      sel_mode;
  logic       sel_toggle;
  logic [3:0] sel_chan;
  logic [6:0] sel_ccnum;
  logic       sel_flag;
  logic       in_range;
  logic       flip;
  logic [6:0] expr_clamped;

  always_comb begin
    sel_mode   = MODE_CC;
    sel_toggle = 1'b0;
    sel_chan   = '0;
    sel_ccnum  = '0;
    sel_flag   = 1'b0;
    for (int i = 0; i < FlagCount; i++) begin
      if (req_i.pedal_index == 3'(i)) begin
        sel_mode   = mode_e'(cfg_i.switch_modes[2*i +: 2]);
        sel_toggle = cfg_i.switch_behaviours[i];
        sel_chan   = cfg_i.switch_channels[4*i +: 4];
        sel_ccnum  = cfg_i.switch_cc_numbers[7*i +: 7];
        sel_flag   = flags_i[i];
      end
    end
  end

  assign in_range = {1'b0, req_i.pedal_index} < 4'(SWITCH_COUNT);

  always_comb begin
    if (req_i.expr_value[15]) begin
      expr_clamped = '0;
    end else if (|req_i.expr_value[14:7]) begin
      expr_clamped = MidiMax;
    end else begin
      expr_clamped = req_i.expr_value[6:0];
    end
  end

  always_comb begin
    res_o      = '0;
    res_o.kind = KIND_CC;
    res_o.chan = sel_chan;
    flip       = 1'b0;
    prog_o     = prog_i;
    if (cfg_i.midi_enabled) begin
      if (req_i.req_type == REQ_EXPR) begin
        res_o.emit   = 1'b1;
        res_o.chan   = cfg_i.expr_channel;
        res_o.number = cfg_i.expr_cc_number;
        res_o.value  = expr_clamped;
      end else if (in_range) begin
        unique case (sel_mode)
          MODE_CC: begin
            res_o.number = sel_ccnum;
            if (sel_toggle) begin
              flip        = req_i.pressed;
              res_o.emit  = req_i.pressed;
              res_o.value = sel_flag ? '0 : MidiMax;
            end else begin
              res_o.emit  = 1'b1;
              res_o.value = req_i.pressed ? MidiMax : '0;
            end
          end
          MODE_PROG_NEXT: begin
            if (req_i.pressed) begin
              prog_o       = prog_i + 7'd1;
              res_o.emit   = 1'b1;
              res_o.kind   = KIND_PC;
              res_o.number = prog_o;
            end
          end
          MODE_PROG_BACK: begin
            if (req_i.pressed) begin
              prog_o       = prog_i - 7'd1;
              res_o.emit   = 1'b1;
              res_o.kind   = KIND_PC;
              res_o.number = prog_o;
            end
          end
          MODE_NONE: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    flags_o = flags_i;
    for (int i = 0; i < FlagCount; i++) begin
      if (flip && req_i.pedal_index == 3'(i)) begin
        flags_o[i] = ~flags_i[i];
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/footswitch_to_midi_mapper.sv
// Footswitch to MIDI mapper top level: config registers, request stage,
// state and output register. Depends on ftm_pkg and ftm_decode.
//
// Usage:
//   Requests (footswitch edges and expression readings) enter on the
//   in_valid_i/in_ready_o channel; MIDI messages leave on the
//   out_valid_o/out_ready_i channel. A request yields zero or one message.
//   Configuration registers are written through cfg_we_i/cfg_index_i/
//   cfg_wdata_i, one register per cycle; the user must write them only
//   while no request is in flight, which the block does not enforce.
//   An accepted request waits in the request register, which feeds the
//   decode; the output register takes its result once it is free.
//   Throughput: one request per cycle unless the output stalls; the decode
//   is a single pass of logic between the request and output registers.
//   When the receiver stalls, the output register holds its message and
//   the request register can still take one more request; a request that
//   yields no message drains even during a stall.
//   Reset clears all configuration registers, the toggle flags, the
//   program number and both valid flags.
`default_nettype none

module footswitch_to_midi_mapper
  import ftm_pkg::*;
#(
  parameter int unsigned SWITCH_COUNT = SwitchCountDflt
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,

  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                req_type_i,
  input  logic [2:0]          pedal_index_i,
  input  logic                pressed_i,
  input  logic signed [15:0]  expr_value_i,

  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                msg_kind_o,
  output logic [3:0]          midi_channel_o,
  output logic [6:0]          number_o,
  output logic [6:0]          cc_value_o
);

  localparam int unsigned FlagCount =
    (SWITCH_COUNT < CfgSwitches) ? SWITCH_COUNT : CfgSwitches;

  ftm_cfg_t             cfg_q;
  ftm_req_t             req_q;
  logic                 req_valid_q;
  logic [FlagCount-1:0] flags_q, flags_d;
  logic [6:0]           prog_q, prog_d;
  ftm_result_t          res;
  ftm_result_t          out_q;
  logic                 out_valid_q;
  logic                 out_free;
  logic                 advance;
  logic                 in_accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MIDI_ENABLED:      cfg_q.midi_enabled      <= cfg_wdata_i[0];
        CFG_SWITCH_MODES:      cfg_q.switch_modes      <= cfg_wdata_i[5:0];
        CFG_SWITCH_BEHAVIOURS: cfg_q.switch_behaviours <= cfg_wdata_i[2:0];
        CFG_SWITCH_CHANNELS:   cfg_q.switch_channels   <= cfg_wdata_i[11:0];
        CFG_SWITCH_CC_NUMBERS: cfg_q.switch_cc_numbers <= cfg_wdata_i[20:0];
        CFG_EXPR_CHANNEL:      cfg_q.expr_channel      <= cfg_wdata_i[3:0];
        CFG_EXPR_CC_NUMBER:    cfg_q.expr_cc_number    <= cfg_wdata_i[6:0];
        default: begin
        end
      endcase
    end
  end

  ftm_decode #(
    .SWITCH_COUNT(SWITCH_COUNT)
  ) u_decode (
    .cfg_i  (cfg_q),
    .req_i  (req_q),
    .flags_i(flags_q),
    .prog_i (prog_q),
    .res_o  (res),
    .flags_o(flags_d),
    .prog_o (prog_d)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = req_valid_q && (out_free || !res.emit);
  assign in_ready_o = !req_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
      prog_q      <= '0;
    end else begin
      if (in_accept) begin
        req_valid_q <= 1'b1;
      end else if (advance) begin
        req_valid_q <= 1'b0;
      end
      if (advance) begin
        flags_q <= flags_d;
        prog_q  <= prog_d;
      end
      if (advance && res.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q.req_type    <= req_type_i;
      req_q.pedal_index <= pedal_index_i;
      req_q.pressed     <= pressed_i;
      req_q.expr_value  <= expr_value_i;
    end
    if (advance && res.emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign msg_kind_o     = out_q.kind;
  assign midi_channel_o = out_q.chan;
  assign number_o       = out_q.number;
  assign cc_value_o     = out_q.value;

endmodule

`default_nettype wire

FILE: hw/rtl/ftm_checker.sv
// Port-level checks for footswitch_to_midi_mapper, bound to the top level.
// Depends on ftm_pkg.
`default_nettype none

module ftm_checker
  import ftm_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               msg_kind_o,
  input logic [3:0]         midi_channel_o,
  input logic [6:0]         number_o,
  input logic [6:0]         cc_value_o
);

  // A stalled message stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("message dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(msg_kind_o) && $stable(midi_channel_o) &&
      $stable(number_o) && $stable(cc_value_o))
    else $error("message changed while stalled");

  // A fresh message always comes from an accepted request.
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("message without a request");

  // Backpressure only comes from a stalled output.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("request side blocked without output stall");

  a_pc_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && msg_kind_o == KIND_PC |-> cc_value_o == 7'd0)
    else $error("program change with nonzero value");

endmodule

bind footswitch_to_midi_mapper ftm_checker u_ftm_checker (.*);

`default_nettype wire
